// ===== src/assert_macros.svh =====
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every edge outside reset
`define ALRPV_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication checked outside reset
`define ALRPV_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/alrpv_pkg.sv =====
// ----------------------------------------------------------------------------
// alrpv_pkg
// types and constants of the abs log return per volume block
// ----------------------------------------------------------------------------
package alrpv_pkg;

	localparam int PRICE_W = 32;
	localparam int VOLUME_W = 32;
	localparam int RATIO_W = 56;
	localparam int VOL_TOT_W = 48;
	localparam int SUM_W = 40;
	localparam int LOG_W = 32;
	localparam int LOG2_FRAC = 28;
	localparam int RATIO_FRAC = 40;
	localparam logic [29:0] LN2_Q30 = 30'd744261118;
	localparam int PRICE_FRAC_BITS_DEF = 16;
	localparam int LOG_FRAC_BITS_DEF = 24;
	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [PRICE_W-1:0]  price;
		logic [VOLUME_W-1:0] volume;
		logic                sample_ok;
		logic                series_end;
	} in_word_t;

	typedef struct packed {
		logic [RATIO_W-1:0] ratio;
		logic               ratio_valid;
	} out_word_t;

	// queued word with its class marked
	typedef struct packed {
		in_word_t word;
		logic     price_zero;
	} q_entry_t;

	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_head_t;

endpackage

// ===== src/alrpv_front.sv =====
// ----------------------------------------------------------------------------
// alrpv_front
// accepts sample words, marks zero prices and holds them in a short queue
// ----------------------------------------------------------------------------
module alrpv_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_stall,
	input  alrpv_pkg::in_word_t sample,
	output alrpv_pkg::q_head_t  head,
	input  logic                pop
);
	import alrpv_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);

	q_entry_t        mem_q [QUEUE_DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [AW:0]     count_q;
	logic            push, do_pop;
	q_entry_t        new_entry;

	// classify the incoming word
	always_comb begin
		new_entry.word = sample;
		new_entry.price_zero = (sample.price == '0);
	end

	assign sample_stall = (count_q == (AW+1)'(QUEUE_DEPTH));
	assign push = sample_valid && !sample_stall;
	assign do_pop = pop && (count_q != '0);

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= new_entry;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !push) count_q <= count_q - 1'b1;
		end
	end

	assign head.valid = (count_q != '0);
	assign head.entry = mem_q[rd_ptr_q];

endmodule

// ===== src/alrpv_back.sv =====
// ----------------------------------------------------------------------------
// alrpv_back
// log by repeated squaring, series sums and a bit-serial divide per series
// ----------------------------------------------------------------------------
module alrpv_back #(
	parameter int PRICE_FRAC_BITS = alrpv_pkg::PRICE_FRAC_BITS_DEF,
	parameter int LOG_FRAC_BITS = alrpv_pkg::LOG_FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  alrpv_pkg::q_head_t   head,
	output logic                 pop,
	output logic                 result_valid,
	input  logic                 result_stall,
	output alrpv_pkg::out_word_t result
);
	import alrpv_pkg::*;

	localparam int SH = LOG2_FRAC + 30 - LOG_FRAC_BITS;
	localparam int SHIFT = RATIO_FRAC - LOG_FRAC_BITS;
	localparam int NW = SUM_W + SHIFT;
	localparam int QW = (NW > RATIO_W) ? NW : RATIO_W + 1;
	localparam int DCW = $clog2(NW + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_SQ, S_MUL, S_ACC, S_END, S_DIV, S_OUT
	} state_t;

	state_t               state_q;
	logic                 end_q;
	logic [31:0]          y_q;
	logic [LOG2_FRAC-1:0] f_q;
	logic [4:0]           msb_q;
	logic [4:0]           cnt_q;
	logic                 neg_q;
	logic [63:0]          prod_q;
	logic [VOL_TOT_W-1:0] vol_q;
	logic [SUM_W-1:0]     sum_q;
	logic [LOG_W-1:0]     prev_q;
	logic                 have_prev_q, poison_q, prev_zero_q;
	logic [NW-1:0]        num_q;
	logic [VOL_TOT_W-1:0] rem_q;
	logic [QW-1:0]        quo_q;
	logic [DCW-1:0]       dcnt_q;
	logic                 out_valid_q;
	out_word_t            out_q;

	// leading one of the price
	logic [4:0] msb_c;
	always_comb begin
		msb_c = '0;
		for (int i = 0; i < 32; i++) begin
			if (head.entry.word.price[i]) msb_c = 5'(i);
		end
	end

	// one squaring step
	logic [63:0] sq;
	logic [32:0] sq_sh;
	assign sq = 64'(y_q) * 64'(y_q);
	assign sq_sh = sq[63:31];

	// integer part and magnitude of log2
	logic signed [6:0] ipart;
	logic [6:0]        ipart_abs;
	logic [33:0]       mag_base, mag;
	assign ipart = $signed({2'b00, msb_q}) - 7'(PRICE_FRAC_BITS);
	assign ipart_abs = ipart[6] ? 7'(-ipart) : 7'(ipart);
	assign mag_base = {27'b0, ipart_abs} << LOG2_FRAC;
	assign mag = ipart[6] ? mag_base - 34'(f_q) : mag_base + 34'(f_q);

	// rounding, clamp and difference
	logic [63:0]        rnd;
	logic [63:0]        lim;
	logic [32:0]        magr;
	logic signed [32:0] lg;
	logic signed [33:0] diff;
	logic [33:0]        adiff;
	logic [SUM_W:0]     sum_next;
	assign rnd = (prod_q + (64'(1) << (SH - 1))) >> SH;
	assign lim = neg_q ? 64'h8000_0000 : 64'h7FFF_FFFF;
	assign magr = (rnd > lim) ? lim[32:0] : rnd[32:0];
	assign lg = neg_q ? -$signed(magr) : $signed(magr);
	assign diff = $signed({lg[32], lg}) - $signed({{2{prev_q[31]}}, prev_q});
	assign adiff = diff[33] ? 34'(-diff) : 34'(diff);
	assign sum_next = {1'b0, sum_q} + (SUM_W+1)'(adiff);

	// volume sum
	logic [VOL_TOT_W:0] vol_next;
	assign vol_next = {1'b0, vol_q} + (VOL_TOT_W+1)'(head.entry.word.volume);

	// restoring divide step
	logic [VOL_TOT_W:0] rem2;
	logic               qbit;
	assign rem2 = {rem_q, num_q[NW-1]};
	assign qbit = (rem2 >= {1'b0, vol_q});

	logic out_free;
	assign out_free = !out_valid_q || !result_stall;
	assign pop = (state_q == S_IDLE) && head.valid;

	// sequencer, series state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vol_q <= '0;
			sum_q <= '0;
			prev_q <= '0;
			have_prev_q <= 1'b0;
			poison_q <= 1'b0;
			prev_zero_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// output word offered until taken
			if (state_q == S_OUT && out_free) out_valid_q <= 1'b1;
			else if (!result_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (head.valid) begin
						end_q <= head.entry.word.series_end;
						msb_q <= msb_c;
						y_q <= head.entry.word.price << (5'd31 - msb_c);
						f_q <= '0;
						cnt_q <= '0;
						if (head.entry.word.sample_ok && !head.entry.price_zero) begin
							state_q <= S_SQ;
						end else begin
							state_q <= S_END;
						end
						if (head.entry.word.sample_ok) begin
							vol_q <= vol_next[VOL_TOT_W] ? '1 : vol_next[VOL_TOT_W-1:0];
							if (head.entry.price_zero) begin
								if (have_prev_q) poison_q <= 1'b1;
								prev_q <= '0;
								prev_zero_q <= 1'b1;
								have_prev_q <= 1'b1;
							end
						end
					end
				end
				S_SQ: begin
					if (sq_sh[32]) begin
						y_q <= sq_sh[32:1];
						f_q <= {f_q[LOG2_FRAC-2:0], 1'b1};
					end else begin
						y_q <= sq_sh[31:0];
						f_q <= {f_q[LOG2_FRAC-2:0], 1'b0};
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 5'(LOG2_FRAC - 1)) state_q <= S_MUL;
				end
				S_MUL: begin
					prod_q <= 64'(mag) * 64'(LN2_Q30);
					neg_q <= ipart[6];
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (have_prev_q) begin
						if (prev_zero_q) begin
							poison_q <= 1'b1;
						end else begin
							sum_q <= sum_next[SUM_W] ? '1 : sum_next[SUM_W-1:0];
						end
					end
					prev_q <= lg[31:0];
					prev_zero_q <= 1'b0;
					have_prev_q <= 1'b1;
					state_q <= S_END;
				end
				S_END: begin
					if (!end_q) begin
						state_q <= S_IDLE;
					end else if (vol_q == '0 || poison_q) begin
						quo_q <= '0;
						state_q <= S_OUT;
					end else begin
						num_q <= {sum_q, SHIFT'(0)};
						rem_q <= '0;
						quo_q <= '0;
						dcnt_q <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= qbit ? VOL_TOT_W'(rem2 - {1'b0, vol_q}) : rem2[VOL_TOT_W-1:0];
					quo_q <= {quo_q[QW-2:0], qbit};
					num_q <= num_q << 1;
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == DCW'(NW - 1)) state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						out_q.ratio_valid <= (vol_q != '0) && !poison_q;
						if ((quo_q >> RATIO_W) != '0) out_q.ratio <= '1;
						else out_q.ratio <= quo_q[RATIO_W-1:0];
						vol_q <= '0;
						sum_q <= '0;
						prev_q <= '0;
						have_prev_q <= 1'b0;
						poison_q <= 1'b0;
						prev_zero_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result_valid = out_valid_q;
	assign result = out_q;

endmodule

// ===== src/abs_log_return_per_volume_top.sv =====
// ----------------------------------------------------------------------------
// abs_log_return_per_volume_top
// sum of absolute log returns of a price series over its total volume
// ----------------------------------------------------------------------------
// channel   dir  valid          stall          word
// sample    in   sample_valid   sample_stall   price, volume, sample_ok, series_end
// result    out  result_valid   result_stall   ratio, ratio_valid
//
// a nonzero usable price passes issue, 28 squaring steps, scaling by ln2,
// accumulation and end check; a zero or skipped sample passes issue and end
// check; a series end adds SUM_W + RATIO_FRAC - LOG_FRAC_BITS (56) divide
// steps and the output state, or only the output state for an invalid result.
// a four-word queue takes samples while the back end works.
// reset clears the queue and all series sums; no clearing pass.
// a stalled result holds in the output register; the back end waits on it.
// ----------------------------------------------------------------------------
module abs_log_return_per_volume_top #(
	parameter int PRICE_FRAC_BITS = alrpv_pkg::PRICE_FRAC_BITS_DEF,
	parameter int LOG_FRAC_BITS = alrpv_pkg::LOG_FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  alrpv_pkg::in_word_t  sample,
	output logic                 result_valid,
	input  logic                 result_stall,
	output alrpv_pkg::out_word_t result
);
	import alrpv_pkg::*;

	q_head_t head;
	logic    pop;

	// front: accept and queue
	alrpv_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.head         (head),
		.pop          (pop)
	);

	// back: log, sums and divide
	alrpv_back #(
		.PRICE_FRAC_BITS (PRICE_FRAC_BITS),
		.LOG_FRAC_BITS   (LOG_FRAC_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// ===== src/alrpv_checker.sv =====
// ----------------------------------------------------------------------------
// alrpv_checker
// port-level checks of the abs log return per volume block
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module alrpv_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 sample_valid,
	input logic                 sample_stall,
	input alrpv_pkg::in_word_t  sample,
	input logic                 result_valid,
	input logic                 result_stall,
	input alrpv_pkg::out_word_t result
);
	import alrpv_pkg::*;

	// a stalled result word stays offered
	`ALRPV_ASSERT_NXT(a_res_hold, clk, arst_n, result_valid && result_stall, result_valid, "result dropped while stalled")

	// and keeps its value
	`ALRPV_ASSERT_NXT(a_res_stable, clk, arst_n, result_valid && result_stall, $stable(result), "stalled result changed")

	// an invalid ratio reads as zero
	`ALRPV_ASSERT_IMP(a_inv_zero, clk, arst_n, result_valid && !result.ratio_valid, result.ratio == '0, "invalid ratio not zero")

	// queue not full and no result just after reset
	`ALRPV_ASSERT_IMP(a_post_reset, clk, arst_n, $past(!arst_n), !sample_stall && !result_valid, "state not clear after reset")

endmodule

bind abs_log_return_per_volume_top alrpv_checker u_checker (.*);

// ===== tb/sv/abs_log_return_per_volume_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// abs_log_return_per_volume_top_tb
// self-checking bench for the abs log return per volume block
// ----------------------------------------------------------------------------
// series of price and volume words are queued by a stimulus process and sent by
// a clocked driver with random gaps; a clocked monitor takes results with random
// stalls and compares them with ratios worked out by a local model of the
// log, accumulation and divide arithmetic
// ----------------------------------------------------------------------------
module abs_log_return_per_volume_top_tb;
	import alrpv_pkg::*;

	localparam int PFB = PRICE_FRAC_BITS_DEF;
	localparam int LFB = LOG_FRAC_BITS_DEF;
	localparam logic [47:0] VOL_FULL = '1;
	localparam logic [39:0] SUM_FULL = '1;
	localparam logic [55:0] RATIO_FULL = '1;

	logic clk;
	logic arst_n;
	logic sample_valid;
	logic sample_stall;
	in_word_t sample;
	logic result_valid;
	logic result_stall;
	out_word_t result;

	abs_log_return_per_volume_top uut (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
		.result_valid(result_valid), .result_stall(result_stall), .result(result)
	);

	// series state of the local model
	logic [47:0] vol_acc;
	logic [39:0] ret_acc;
	logic signed [31:0] last_ln;
	logic seen_any, tainted, last_was_zero;

	in_word_t pending_words[$];
	out_word_t expected_ratios[$];
	int errors;
	bit send_pause;
	bit hold_result;
	bit gaps_on;

	// natural log of a nonzero price, signed fixed point
	function automatic logic signed [31:0] price_ln(input logic [31:0] raw);
		int msb;
		logic [63:0] y, f, mag, lim;
		logic [127:0] sq;
		int ip;
		bit neg;
		int sh;
		msb = 31;
		while (msb > 0 && raw[msb] == 1'b0) msb--;
		y = 64'(raw) << (31 - msb);
		f = 0;
		for (int i = 0; i < LOG2_FRAC; i++) begin
			sq = 128'(y) * 128'(y);
			y = 64'(sq >> 31);
			f = f << 1;
			if (y >= 64'h1_0000_0000) begin
				y = y >> 1;
				f[0] = 1'b1;
			end
		end
		ip = msb - PFB;
		neg = ip < 0;
		if (neg) mag = (64'(-ip) << LOG2_FRAC) - f;
		else mag = (64'(ip) << LOG2_FRAC) + f;
		mag = mag * 64'(LN2_Q30);
		sh = LOG2_FRAC + 30 - LFB;
		mag = (mag + (64'd1 << (sh - 1))) >> sh;
		lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
		if (mag > lim) mag = lim;
		return neg ? 32'(-mag) : 32'(mag);
	endfunction

	// quotient in Q16.40, saturating
	function automatic logic [55:0] ratio_of(input logic [63:0] num, input logic [63:0] den);
		int s;
		logic [63:0] q, r;
		s = RATIO_FRAC - LFB;
		q = num / den;
		r = num % den;
		if ((q >> (56 - s)) != 0) return RATIO_FULL;
		for (int i = 0; i < s; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q[0] = 1'b1;
			end
		end
		return q[55:0];
	endfunction

	task automatic clear_series();
		vol_acc = 0;
		ret_acc = 0;
		last_ln = 0;
		seen_any = 0;
		tainted = 0;
		last_was_zero = 0;
	endtask

	// update the series sums for one accepted word
	task automatic absorb_word(input in_word_t w);
		logic [48:0] vs;
		logic signed [33:0] d;
		logic [40:0] rs;
		logic signed [31:0] lg;
		out_word_t o;
		if (w.sample_ok) begin
			vs = 49'(vol_acc) + 49'(w.volume);
			vol_acc = (vs > 49'(VOL_FULL)) ? VOL_FULL : vs[47:0];
			if (w.price == 0) begin
				if (seen_any) tainted = 1;
				last_ln = 0;
				last_was_zero = 1;
			end else begin
				lg = price_ln(w.price);
				if (seen_any) begin
					if (last_was_zero) tainted = 1;
					else begin
						d = 34'(lg) - 34'(last_ln);
						if (d < 0) d = -d;
						rs = 41'(ret_acc) + 41'(d);
						ret_acc = (rs > 41'(SUM_FULL)) ? SUM_FULL : rs[39:0];
					end
				end
				last_ln = lg;
				last_was_zero = 0;
			end
			seen_any = 1;
		end
		if (w.series_end) begin
			if (vol_acc != 0 && !tainted) begin
				o.ratio = ratio_of(64'(ret_acc), 64'(vol_acc));
				o.ratio_valid = 1;
			end else begin
				o.ratio = 0;
				o.ratio_valid = 0;
			end
			expected_ratios.push_back(o);
			clear_series();
		end
	endtask

	task automatic report_mismatch(input string what);
		errors++;
		$display("mismatch at %0t: %s", $realtime, what);
	endtask

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// driver: words from the pending queue, random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 0;
			sample <= '0;
		end else begin
			if (sample_valid && !sample_stall) absorb_word(sample);
			if (sample_valid && sample_stall) begin
				// hold
			end else if (pending_words.size() > 0 && !send_pause &&
					(!gaps_on || $urandom_range(99) >= 23)) begin
				sample_valid <= 1;
				sample <= pending_words.pop_front();
			end else begin
				sample_valid <= 0;
			end
		end
	end

	// monitor: random stalls, compare with oldest expectation
	always @(posedge clk or negedge arst_n) begin
		out_word_t e;
		if (!arst_n) begin
			result_stall <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_ratios.size() == 0) report_mismatch("result with none expected");
				else begin
					e = expected_ratios.pop_front();
					if (result.ratio_valid !== e.ratio_valid)
						report_mismatch($sformatf("ratio_valid %b want %b",
							result.ratio_valid, e.ratio_valid));
					if (result.ratio !== e.ratio)
						report_mismatch($sformatf("ratio %h want %h", result.ratio, e.ratio));
				end
			end
			result_stall <= hold_result || (gaps_on && $urandom_range(99) < 23);
		end
	end

	// random price with a spread of magnitudes
	function automatic logic [31:0] any_price();
		case ($urandom_range(9))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return 32'(1) << $urandom_range(31);
			3, 4: return $urandom();
			default: return 32'h0001_0000 + $urandom_range(32'h4000) - 32'h2000;
		endcase
	endfunction

	function automatic logic [31:0] any_volume();
		case ($urandom_range(7))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom();
			default: return $urandom_range(1000);
		endcase
	endfunction

	task automatic queue_word(input logic [31:0] p, input logic [31:0] v,
			input logic ok, input logic fin);
		in_word_t w;
		w.price = p;
		w.volume = v;
		w.sample_ok = ok;
		w.series_end = fin;
		pending_words.push_back(w);
	endtask

	task automatic wait_drained();
		while (pending_words.size() > 0 || sample_valid || expected_ratios.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		int n, len;
		errors = 0;
		gaps_on = 1;
		send_pause = 0;
		hold_result = 0;
		clear_series();
		arst_n = 0;
		sample_valid = 0;
		sample = '0;
		result_stall = 0;
		repeat (6) @(posedge clk);
		arst_n = 1;

		// directed: plain series, extremes, zero price, zero volume, skipped end
		queue_word(32'h0001_0000, 32'd10, 1, 0);
		queue_word(32'h0002_0000, 32'd10, 1, 0);
		queue_word(32'h0001_8000, 32'd5, 1, 1);
		queue_word(32'h0000_0001, 32'hFFFF_FFFF, 1, 0);
		queue_word(32'hFFFF_FFFF, 32'd1, 1, 1);
		queue_word(32'h0000_0001, 32'd1, 1, 0);
		queue_word(32'hFFFF_FFFF, 32'd0, 1, 0);
		queue_word(32'h0000_0001, 32'd0, 1, 1);
		queue_word(32'd0, 32'd7, 1, 1);
		queue_word(32'h0001_0000, 32'd3, 1, 0);
		queue_word(32'd0, 32'd3, 1, 1);
		queue_word(32'd0, 32'd3, 1, 0);
		queue_word(32'h0001_0000, 32'd3, 1, 1);
		queue_word(32'h0003_0000, 32'd0, 1, 0);
		queue_word(32'h0001_0000, 32'd0, 1, 1);
		queue_word(32'h0001_0000, 32'd4, 1, 0);
		queue_word(32'h0004_0000, 32'd4, 0, 0);
		queue_word(32'h0002_0000, 32'd4, 1, 0);
		queue_word(32'd0, 32'hFFFF_FFFF, 0, 1);
		queue_word(32'h1234_5678, 32'd9, 0, 1);
		for (int i = 0; i < 4; i++) queue_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, i == 3);

		// long result hold-off while the sender keeps offering words
		while (pending_words.size() >= 10) @(posedge clk);
		hold_result = 1;
		repeat (300) @(posedge clk);
		hold_result = 0;

		// stimulus waits for every expected result
		wait_drained();

		// random series, mostly well formed, a stretch without gaps
		n = 0;
		while (n < 660) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(6, 1);
			for (int i = 0; i < len; i++) begin
				queue_word(any_price(), any_volume(), $urandom_range(9) != 0, i == len - 1);
				n++;
			end
			if (n > 300 && n < 450) gaps_on = 0;
			else gaps_on = 1;
			while (pending_words.size() > 20) @(posedge clk);
		end
		// a long stretch of short series with no idling
		wait_drained();
		gaps_on = 0;
		for (int i = 0; i < 60; i++)
			queue_word($urandom(), $urandom(), 1'($urandom_range(1)),
				$urandom_range(3) == 0);
		queue_word(32'h0001_0000, 32'd1, 1, 1);
		wait_drained();
		gaps_on = 1;
		repeat (200) @(posedge clk);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("timeout");
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/alrpv_pkg.sv
src/alrpv_front.sv
src/alrpv_back.sv
src/abs_log_return_per_volume_top.sv
src/alrpv_checker.sv
tb/sv/abs_log_return_per_volume_top_tb.sv
